@@ hw/rtl/gcg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grey conversion package
// Shared field widths, opcodes, register indexes and grey level constants.
// ----------------------------------------------------------------------------
package gcg_pkg;

    localparam int CHANNEL_W     = 8;
    localparam int WEIGHT_W      = 16;
    localparam int PRODUCT_W     = CHANNEL_W + WEIGHT_W;
    localparam int SUM_W         = PRODUCT_W + 2;
    localparam int GREY_Q_W      = PRODUCT_W;
    localparam int GREY_W        = 8;
    localparam int ENTRY_INDEX_W = 10;
    localparam int ENTRY_VALUE_W = 8;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [GREY_Q_W-1:0] GREY_MAX_Q16 = 24'hFF_0000;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_WRITE = 1'b1
    } t_opcode;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WEIGHT_RED   = 2'd0,
        REG_WEIGHT_GREEN = 2'd1,
        REG_WEIGHT_BLUE  = 2'd2,
        REG_BYPASS_GAMMA = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic [WEIGHT_W-1:0] red;
        logic [WEIGHT_W-1:0] green;
        logic [WEIGHT_W-1:0] blue;
    } t_weights;

endpackage
`default_nettype wire

@@ hw/rtl/gcg_luma.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grey conversion luma stage
// Registers the three weighted channel products and forms the clamped
// Q8.16 grey level from them.
// ----------------------------------------------------------------------------
module gcg_luma (
    input  wire                               i_clk,
    input  wire                               i_en,
    input  wire  [gcg_pkg::CHANNEL_W-1:0]     i_red,
    input  wire  [gcg_pkg::CHANNEL_W-1:0]     i_green,
    input  wire  [gcg_pkg::CHANNEL_W-1:0]     i_blue,
    input  gcg_pkg::t_weights                 i_weights,
    output logic [gcg_pkg::GREY_Q_W-1:0]      o_grey_q
);
    import gcg_pkg::*;

    logic [PRODUCT_W-1:0] r_prod_red;
    logic [PRODUCT_W-1:0] r_prod_green;
    logic [PRODUCT_W-1:0] r_prod_blue;
    logic [SUM_W-1:0]     sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_red   <= PRODUCT_W'(i_weights.red)   * PRODUCT_W'(i_red);
            r_prod_green <= PRODUCT_W'(i_weights.green) * PRODUCT_W'(i_green);
            r_prod_blue  <= PRODUCT_W'(i_weights.blue)  * PRODUCT_W'(i_blue);
        end
    end

    always_comb begin
        sum = SUM_W'(r_prod_red) + SUM_W'(r_prod_green) + SUM_W'(r_prod_blue);
        if (sum > SUM_W'(GREY_MAX_Q16)) begin
            o_grey_q = GREY_MAX_Q16;
        end else begin
            o_grey_q = sum[GREY_Q_W-1:0];
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/grey_conversion_gamma_lut_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grey conversion with gamma table, top level
// A pixel word passes the input register, the luma product registers and the
// output register (stages s1, s2, s3) before it shows on the output.
// Throughput: one word per cycle while the output is not stalled; a table write takes one slot, no result.
// The table port is single ported; a write or a read happens in one stage.
// Reset clears the pipeline and loads the default weights and bypass mode.
// Gamma table contents are undefined until written.
// ----------------------------------------------------------------------------
module grey_conversion_gamma_lut_top #(
    parameter int TABLE_INDEX_BITS = 10
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [gcg_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  wire  [gcg_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  gcg_pkg::t_opcode                      i_opcode,
    input  wire  [gcg_pkg::CHANNEL_W-1:0]         i_red,
    input  wire  [gcg_pkg::CHANNEL_W-1:0]         i_green,
    input  wire  [gcg_pkg::CHANNEL_W-1:0]         i_blue,
    input  wire                                   i_end_of_image,
    input  wire  [gcg_pkg::ENTRY_INDEX_W-1:0]     i_entry_index,
    input  wire  [gcg_pkg::ENTRY_VALUE_W-1:0]     i_entry_value,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic [gcg_pkg::GREY_W-1:0]            o_grey_level,
    output logic                                  o_end_of_image_out
);
    import gcg_pkg::*;

    localparam int TABLE_DEPTH = 1 << TABLE_INDEX_BITS;
    localparam int EXT_W       = ENTRY_INDEX_W + TABLE_INDEX_BITS;

    t_weights                    r_weights;
    logic                        r_bypass;

    logic                        adv1;
    logic                        adv2;
    logic                        adv3;

    logic                        r_s1_valid;
    t_opcode                     r_s1_op;
    logic [CHANNEL_W-1:0]        r_s1_red;
    logic [CHANNEL_W-1:0]        r_s1_green;
    logic [CHANNEL_W-1:0]        r_s1_blue;
    logic                        r_s1_eoi;
    logic [TABLE_INDEX_BITS-1:0] r_s1_widx;
    logic [ENTRY_VALUE_W-1:0]    r_s1_wval;
    logic [EXT_W-1:0]            widx_ext;

    logic                        r_s2_valid;
    t_opcode                     r_s2_op;
    logic                        r_s2_eoi;
    logic [TABLE_INDEX_BITS-1:0] r_s2_widx;
    logic [ENTRY_VALUE_W-1:0]    r_s2_wval;
    logic [GREY_Q_W-1:0]         grey_q;
    logic [TABLE_INDEX_BITS-1:0] rd_idx;

    logic                        r_s3_valid;
    logic [GREY_W-1:0]           r_s3_grey;
    logic                        r_s3_eoi;
    logic [GREY_W-1:0]           r_rdata;

    logic [ENTRY_VALUE_W-1:0]    gamma_mem [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights.red   <= WEIGHT_W'(19595);
            r_weights.green <= WEIGHT_W'(38470);
            r_weights.blue  <= WEIGHT_W'(7471);
            r_bypass        <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WEIGHT_RED:   r_weights.red   <= i_cfg_data;
                REG_WEIGHT_GREEN: r_weights.green <= i_cfg_data;
                REG_WEIGHT_BLUE:  r_weights.blue  <= i_cfg_data;
                REG_BYPASS_GAMMA: r_bypass        <= i_cfg_data[0];
            endcase
        end
    end

    assign adv3       = !r_s3_valid || i_out_ready;
    assign adv2       = !r_s2_valid || adv3;
    assign adv1       = !r_s1_valid || adv2;
    assign o_in_ready = adv1;

    assign widx_ext = {{TABLE_INDEX_BITS{1'b0}}, i_entry_index};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv1) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_in_valid) begin
            r_s1_op    <= i_opcode;
            r_s1_red   <= i_red;
            r_s1_green <= i_green;
            r_s1_blue  <= i_blue;
            r_s1_eoi   <= i_end_of_image;
            r_s1_widx  <= widx_ext[TABLE_INDEX_BITS-1:0];
            r_s1_wval  <= i_entry_value;
        end
    end

    gcg_luma u_luma (
        .i_clk     (i_clk),
        .i_en      (adv2 && r_s1_valid),
        .i_red     (r_s1_red),
        .i_green   (r_s1_green),
        .i_blue    (r_s1_blue),
        .i_weights (r_weights),
        .o_grey_q  (grey_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2 && r_s1_valid) begin
            r_s2_op   <= r_s1_op;
            r_s2_eoi  <= r_s1_eoi;
            r_s2_widx <= r_s1_widx;
            r_s2_wval <= r_s1_wval;
        end
    end

    assign rd_idx = grey_q[GREY_Q_W-1 -: TABLE_INDEX_BITS];

    always_ff @(posedge i_clk) begin
        if (adv3 && r_s2_valid) begin
            if (r_s2_op == OP_WRITE) begin
                gamma_mem[r_s2_widx] <= r_s2_wval;
            end else begin
                r_rdata <= gamma_mem[rd_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (adv3) begin
            r_s3_valid <= r_s2_valid && (r_s2_op == OP_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3 && r_s2_valid && (r_s2_op == OP_PIXEL)) begin
            r_s3_grey <= grey_q[GREY_Q_W-1 -: GREY_W];
            r_s3_eoi  <= r_s2_eoi;
        end
    end

    assign o_out_valid        = r_s3_valid;
    assign o_grey_level       = r_bypass ? r_s3_grey : r_rdata;
    assign o_end_of_image_out = r_s3_eoi;

endmodule
`default_nettype wire

@@ hw/rtl/gcg_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grey conversion port checker
// Watches the top level ports for flow control and latency slips.
// ----------------------------------------------------------------------------
module gcg_checker (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    input  wire                                   o_in_ready,
    input  gcg_pkg::t_opcode                      i_opcode,
    input  wire                                   o_out_valid,
    input  wire                                   i_out_ready,
    input  wire  [gcg_pkg::GREY_W-1:0]            o_grey_level,
    input  wire                                   o_end_of_image_out
);
    import gcg_pkg::*;

    logic in_pixel_acc;

    assign in_pixel_acc = i_in_valid && o_in_ready && (i_opcode == OP_PIXEL);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_grey_level) && $stable(o_end_of_image_out))
        else $error("Stalled output word changed.");

    a_no_stall_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid || i_out_ready |-> o_in_ready)
        else $error("Input stalled while the output side is free.");

    a_pixel_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_pixel_acc ##1 i_out_ready ##1 i_out_ready |=> o_out_valid)
        else $error("Pixel word did not reach the output two cycles after acceptance.");

endmodule

bind grey_conversion_gamma_lut_top gcg_checker u_gcg_checker (.*);
`default_nettype wire

@@ sim/grey_conversion_gamma_lut_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grey conversion with gamma table, testbench
// Drives pixel and table-load words through the valid/ready input, tracks the
// weights, the bypass mode and the loaded table entries in its own copy, and
// checks every output word in order against the predicted grey level and
// end-of-image flag. A short directed table comes first, then random images
// under changing weights, gamma modes and stall patterns on both sides.
// ----------------------------------------------------------------------------
module grey_conversion_gamma_lut_top_tb;

    import gcg_pkg::*;

    localparam int TABLE_INDEX_BITS = 10;
    localparam int FRAC_BITS        = TABLE_INDEX_BITS - 8;
    localparam int TABLE_DEPTH      = 1 << TABLE_INDEX_BITS;
    localparam logic [SUM_W-1:0] GREY_CLAMP_Q16 = 26'd255 << 16;
    localparam int SETTLE_CYCLES    = 8;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int SEGMENT_COUNT    = 6;
    localparam int SEGMENT_WORDS    = 105;
    localparam int HOLD_CYCLES      = 300;

    typedef struct packed {
        logic [GREY_W-1:0] grey;
        logic              eoi;
    } t_grey_word;

    typedef enum logic {
        ROW_WORD,
        ROW_REG
    } t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        t_reg_index               reg_index;
        logic [CFG_DATA_W-1:0]    reg_data;
        t_opcode                  opcode;
        logic [CHANNEL_W-1:0]     red;
        logic [CHANNEL_W-1:0]     green;
        logic [CHANNEL_W-1:0]     blue;
        logic                     eoi;
        logic [ENTRY_INDEX_W-1:0] entry_index;
        logic [ENTRY_VALUE_W-1:0] entry_value;
        logic                     known;
        logic [GREY_W-1:0]        known_grey;
    } t_stim_row;

    logic                     i_clk              = 1'b0;
    logic                     i_rst_n            = 1'b0;
    logic                     i_cfg_we           = 1'b0;
    logic [CFG_INDEX_W-1:0]   i_cfg_index        = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data         = '0;
    logic                     i_in_valid         = 1'b0;
    logic                     o_in_ready;
    t_opcode                  i_opcode           = OP_PIXEL;
    logic [CHANNEL_W-1:0]     i_red              = '0;
    logic [CHANNEL_W-1:0]     i_green            = '0;
    logic [CHANNEL_W-1:0]     i_blue             = '0;
    logic                     i_end_of_image     = 1'b0;
    logic [ENTRY_INDEX_W-1:0] i_entry_index      = '0;
    logic [ENTRY_VALUE_W-1:0] i_entry_value      = '0;
    logic                     o_out_valid;
    logic                     i_out_ready        = 1'b0;
    logic [GREY_W-1:0]        o_grey_level;
    logic                     o_end_of_image_out;

    logic [WEIGHT_W-1:0]      model_w_red   = 16'd19595;
    logic [WEIGHT_W-1:0]      model_w_green = 16'd38470;
    logic [WEIGHT_W-1:0]      model_w_blue  = 16'd7471;
    logic                     model_bypass  = 1'b1;
    logic [GREY_W-1:0]        gamma_copy   [TABLE_DEPTH];
    bit                       gamma_loaded [TABLE_DEPTH];

    t_grey_word               grey_expected_q [$];
    t_grey_word               landed_exp;
    t_stim_row                directed_rows [$];
    int                       mismatch_count = 0;
    int                       tx_idle_pct    = 23;
    int                       rx_idle_pct    = 63;
    bit                       rx_hold_req    = 1'b0;
    bit                       rx_hold_taken  = 1'b0;
    int                       rx_hold_left   = 0;
    int                       cycle_count    = 0;

    grey_conversion_gamma_lut_top #(
        .TABLE_INDEX_BITS(TABLE_INDEX_BITS)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (i_opcode),
        .i_red             (i_red),
        .i_green           (i_green),
        .i_blue            (i_blue),
        .i_end_of_image    (i_end_of_image),
        .i_entry_index     (i_entry_index),
        .i_entry_value     (i_entry_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_grey_level      (o_grey_level),
        .o_end_of_image_out(o_end_of_image_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [SUM_W-1:0] clamped_sum(logic [CHANNEL_W-1:0] r,
                                                     logic [CHANNEL_W-1:0] g,
                                                     logic [CHANNEL_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(model_w_red) * SUM_W'(r) + SUM_W'(model_w_green) * SUM_W'(g)
            + SUM_W'(model_w_blue) * SUM_W'(b);
        if (s > GREY_CLAMP_Q16) begin
            s = GREY_CLAMP_Q16;
        end
        return s;
    endfunction

    function automatic logic [TABLE_INDEX_BITS-1:0] table_index_of(logic [CHANNEL_W-1:0] r,
                                                                   logic [CHANNEL_W-1:0] g,
                                                                   logic [CHANNEL_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = clamped_sum(r, g, b) >> (16 - FRAC_BITS);
        return s[TABLE_INDEX_BITS-1:0];
    endfunction

    function automatic logic [GREY_W-1:0] predict_grey(logic [CHANNEL_W-1:0] r,
                                                       logic [CHANNEL_W-1:0] g,
                                                       logic [CHANNEL_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = clamped_sum(r, g, b);
        if (model_bypass) begin
            return s[GREY_Q_W-1:16];
        end
        return gamma_copy[table_index_of(r, g, b)];
    endfunction

    function automatic logic [CHANNEL_W-1:0] pick_channel();
        int c;
        c = $urandom_range(0, 9);
        if (c == 0) begin
            return 8'd0;
        end else if (c == 1) begin
            return 8'd255;
        end
        return CHANNEL_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 3))
            0: begin
                return 16'd0;
            end
            1: begin
                return 16'hFFFF;
            end
            default: begin
                return WEIGHT_W'($urandom_range(0, 65535));
            end
        endcase
    endfunction

    task automatic row_word(t_opcode op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic eoi, logic [9:0] idx, logic [7:0] val,
                            logic known, logic [7:0] known_grey);
        t_stim_row row;
        row             = '0;
        row.kind        = ROW_WORD;
        row.opcode      = op;
        row.red         = r;
        row.green       = g;
        row.blue        = b;
        row.eoi         = eoi;
        row.entry_index = idx;
        row.entry_value = val;
        row.known       = known;
        row.known_grey  = known_grey;
        directed_rows.push_back(row);
    endtask

    task automatic row_reg(t_reg_index idx, logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row           = '0;
        row.kind      = ROW_REG;
        row.reg_index = idx;
        row.reg_data  = data;
        directed_rows.push_back(row);
    endtask

    task automatic write_register(t_reg_index idx, logic [CFG_DATA_W-1:0] data);
        i_in_valid <= 1'b0;
        while (grey_expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_WEIGHT_RED: begin
                model_w_red = data;
            end
            REG_WEIGHT_GREEN: begin
                model_w_green = data;
            end
            REG_WEIGHT_BLUE: begin
                model_w_blue = data;
            end
            REG_BYPASS_GAMMA: begin
                model_bypass = data[0];
            end
        endcase
    endtask

    task automatic send_word(t_opcode op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic eoi, logic [9:0] idx, logic [7:0] val,
                             logic known, logic [7:0] known_grey);
        t_grey_word w;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_red          <= r;
        i_green        <= g;
        i_blue         <= b;
        i_end_of_image <= eoi;
        i_entry_index  <= idx;
        i_entry_value  <= val;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        if (op == OP_WRITE) begin
            gamma_copy[idx[TABLE_INDEX_BITS-1:0]]   = val;
            gamma_loaded[idx[TABLE_INDEX_BITS-1:0]] = 1'b1;
        end else begin
            w.grey = known ? known_grey : predict_grey(r, g, b);
            w.eoi  = eoi;
            grey_expected_q.push_back(w);
        end
    endtask

    task automatic send_table_load(logic [9:0] idx);
        send_word(OP_WRITE, CHANNEL_W'($urandom_range(0, 255)),
                  CHANNEL_W'($urandom_range(0, 255)),
                  CHANNEL_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), idx,
                  ENTRY_VALUE_W'($urandom_range(0, 255)), 1'b0, 8'd0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (grey_expected_q.size() == 0) begin
                $error("unexpected word: grey_level %0d, end_of_image_out %0b",
                       o_grey_level, o_end_of_image_out);
                mismatch_count++;
            end else begin
                landed_exp = grey_expected_q.pop_front();
                if (o_grey_level !== landed_exp.grey) begin
                    $error("grey_level: expected %0d, actual %0d",
                           landed_exp.grey, o_grey_level);
                    mismatch_count++;
                end
                if (o_end_of_image_out !== landed_exp.eoi) begin
                    $error("end_of_image_out: expected %0b, actual %0b",
                           landed_exp.eoi, o_end_of_image_out);
                    mismatch_count++;
                end
            end
        end
        if (rx_hold_req && !rx_hold_taken) begin
            rx_hold_taken = 1'b1;
            rx_hold_left  = HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_stim_row            row;
        int                   seg;
        int                   words;
        int                   image_left;
        logic [CHANNEL_W-1:0] r;
        logic [CHANNEL_W-1:0] g;
        logic [CHANNEL_W-1:0] b;
        logic [9:0]           idx;
        logic                 eoi;

        row_word(OP_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, 10'd0, 8'd0, 1'b1, 8'd0);
        row_word(OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b1, 10'h3FF, 8'hFF, 1'b1, 8'd255);
        row_word(OP_PIXEL, 8'd255, 8'd0, 8'd0, 1'b0, 10'd0, 8'd0, 1'b0, 8'd0);
        row_word(OP_PIXEL, 8'd0, 8'd255, 8'd0, 1'b0, 10'd0, 8'd0, 1'b0, 8'd0);
        row_word(OP_PIXEL, 8'd0, 8'd0, 8'd255, 1'b1, 10'd0, 8'd0, 1'b0, 8'd0);
        row_word(OP_PIXEL, 8'h80, 8'h40, 8'h20, 1'b0, 10'h2AA, 8'h55, 1'b0, 8'd0);
        row_word(OP_WRITE, 8'd255, 8'd255, 8'd255, 1'b1, 10'h3FF, 8'hFF, 1'b0, 8'd0);
        row_word(OP_WRITE, 8'd0, 8'd0, 8'd0, 1'b0, 10'h000, 8'h33, 1'b0, 8'd0);
        row_word(OP_WRITE, 8'hA5, 8'h5A, 8'hC3, 1'b0, 10'h3FC, 8'h5A, 1'b0, 8'd0);
        row_reg(REG_WEIGHT_RED, 16'hFFFF);
        row_reg(REG_WEIGHT_GREEN, 16'hFFFF);
        row_reg(REG_WEIGHT_BLUE, 16'hFFFF);
        row_word(OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, 10'd0, 8'd0, 1'b1, 8'd255);
        row_word(OP_PIXEL, 8'd1, 8'd1, 8'd1, 1'b1, 10'd0, 8'd0, 1'b0, 8'd0);
        row_reg(REG_BYPASS_GAMMA, 16'd0);
        row_word(OP_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, 10'd0, 8'd0, 1'b1, 8'h33);
        row_word(OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b1, 10'd0, 8'd0, 1'b1, 8'h5A);
        row_word(OP_WRITE, 8'd0, 8'd0, 8'd0, 1'b0, 10'h000, 8'hE1, 1'b0, 8'd0);
        row_word(OP_PIXEL, 8'd0, 8'd0, 8'd0, 1'b1, 10'd0, 8'd0, 1'b1, 8'hE1);
        row_reg(REG_WEIGHT_RED, 16'd0);
        row_reg(REG_WEIGHT_GREEN, 16'd0);
        row_reg(REG_WEIGHT_BLUE, 16'd0);
        row_word(OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, 10'd0, 8'd0, 1'b1, 8'hE1);
        row_reg(REG_BYPASS_GAMMA, 16'd1);
        row_word(OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b1, 10'd0, 8'd0, 1'b1, 8'd0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_REG) begin
                write_register(row.reg_index, row.reg_data);
            end else begin
                send_word(row.opcode, row.red, row.green, row.blue, row.eoi,
                          row.entry_index, row.entry_value, row.known, row.known_grey);
            end
        end

        for (seg = 0; seg < SEGMENT_COUNT; seg++) begin
            case (seg / 2)
                0: begin
                    tx_idle_pct = 23;
                    rx_idle_pct = 63;
                end
                1: begin
                    tx_idle_pct = 63;
                    rx_idle_pct = 23;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            if (seg == 2) begin
                write_register(REG_WEIGHT_RED, 16'hFFFF);
                write_register(REG_WEIGHT_GREEN, 16'hFFFF);
                write_register(REG_WEIGHT_BLUE, 16'hFFFF);
            end else if (seg == 4) begin
                write_register(REG_WEIGHT_RED, 16'd19595);
                write_register(REG_WEIGHT_GREEN, 16'd38470);
                write_register(REG_WEIGHT_BLUE, 16'd7471);
            end else begin
                write_register(REG_WEIGHT_RED, pick_weight());
                write_register(REG_WEIGHT_GREEN, pick_weight());
                write_register(REG_WEIGHT_BLUE, pick_weight());
            end
            write_register(REG_BYPASS_GAMMA, CFG_DATA_W'(seg % 2));
            if (seg == SEGMENT_COUNT - 1) begin
                rx_hold_req = 1'b1;
            end

            words      = 0;
            image_left = $urandom_range(1, 16);
            while (words < SEGMENT_WORDS) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_table_load(ENTRY_INDEX_W'($urandom_range(0, 1023)));
                    words++;
                end else begin
                    r = pick_channel();
                    g = pick_channel();
                    b = pick_channel();
                    if (!model_bypass && !gamma_loaded[table_index_of(r, g, b)]) begin
                        idx = ENTRY_INDEX_W'(table_index_of(r, g, b));
                        send_table_load(idx);
                        words++;
                    end
                    image_left--;
                    eoi = (image_left == 0);
                    if (eoi) begin
                        image_left = $urandom_range(1, 16);
                    end
                    send_word(OP_PIXEL, r, g, b, eoi,
                              ENTRY_INDEX_W'($urandom_range(0, 1023)),
                              ENTRY_VALUE_W'($urandom_range(0, 255)), 1'b0, 8'd0);
                    words++;
                end
            end
        end

        i_in_valid <= 1'b0;
        while (grey_expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES * 4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
